// File: rtl/etcm_pkg.sv
// ----------------------------------------------------------------------------
// etcm_pkg
// Shared types and codes for the exon table coordinate mapper.
// ----------------------------------------------------------------------------
package etcm_pkg;

  // genome coordinate and transcript position widths
  localparam int COORD_W = 31;
  localparam int POS_W   = 32;

  // request operation codes
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_MAP    = 2'd2,
    MODE_SPLIT  = 2'd3
  } mode_t;

  // result segment kinds
  typedef enum logic [1:0] {
    KIND_UTR5 = 2'd0,
    KIND_CDS  = 2'd1,
    KIND_UTR3 = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_UNMAPPED  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_WALK,
    S_MAP_OUT,
    S_SPL_CLASS,
    S_SPL_EMIT
  } state_t;

  // placement of one exon against the lower and upper coding bounds
  typedef enum logic [2:0] {
    SPL_BELOW,
    SPL_ENTER,
    SPL_SPAN,
    SPL_INSIDE,
    SPL_ABOVE,
    SPL_LEAVE
  } split_case_t;

  // one exon table entry
  typedef struct packed {
    logic [COORD_W-1:0] first;
    logic [COORD_W-1:0] last;
  } exon_t;

endpackage

// File: rtl/etcm_in_if.sv
// ----------------------------------------------------------------------------
// etcm_in_if
// Request channel of the exon table coordinate mapper.
// ----------------------------------------------------------------------------
interface etcm_in_if;

  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [30:0] exon_first;
  logic [30:0] exon_last;
  logic [31:0] rna_position;
  logic [30:0] cds_start;
  logic [30:0] cds_stop;

  modport source (
    output valid, mode, exon_first, exon_last, rna_position, cds_start, cds_stop,
    input  ready
  );

  modport sink (
    input  valid, mode, exon_first, exon_last, rna_position, cds_start, cds_stop,
    output ready
  );

endinterface

// File: rtl/etcm_out_if.sv
// ----------------------------------------------------------------------------
// etcm_out_if
// Result channel of the exon table coordinate mapper.
// ----------------------------------------------------------------------------
interface etcm_out_if;

  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [30:0] seg_start;
  logic [31:0] seg_end;
  logic [31:0] mapped_pos;
  logic [1:0]  status;
  logic        last;

  modport source (
    output valid, kind, seg_start, seg_end, mapped_pos, status, last,
    input  ready
  );

  modport sink (
    input  valid, kind, seg_start, seg_end, mapped_pos, status, last,
    output ready
  );

endinterface

// File: rtl/etcm_table.sv
// ----------------------------------------------------------------------------
// etcm_table
// Exon interval store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module etcm_table
  import etcm_pkg::*;
#(
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  exon_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output exon_t             rd_data
);

  exon_t mem_r [DEPTH];
  exon_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/exon_table_coordinate_mapper_core.sv
// ----------------------------------------------------------------------------
// exon_table_coordinate_mapper_core
// Exon table with append, clear, transcript-to-genome map and UTR/CDS split.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one request per valid/ready handshake; mode picks append,
//   clear, map or split. out_if returns one or more results per request, the
//   final one flagged by last. cfg_we/cfg_wdata write the strand bit; the user
//   must do so only while no request is in flight; the block does not enforce this.
// Flow:
//   append, clear, and map or split on an empty table: result registered in the
//   cycle after the request. map: walks the exons in order through the table
//   read port (one entry a cycle), then loads the result from S_MAP_OUT.
//   split: per exon a classify state, then one emit step per segment,
//   up to three per exon. in_if.ready is low until the last result
//   of the current request has been loaded into the output register.
// Reset:
//   clears the exon count, strand and sequencer; table contents are left
//   as they are and never read before written.
// Stall:
//   a result waits in the output register while out_if.ready is low and the
//   sequencer holds in its result-loading states until the register frees.
// ----------------------------------------------------------------------------
module exon_table_coordinate_mapper_core
  import etcm_pkg::*;
#(
  parameter int MAX_EXONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  etcm_in_if.sink     in_if,
  etcm_out_if.source  out_if
);

  localparam int CNT_W = $clog2(MAX_EXONS + 1);
  localparam int IDX_W = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_EXONS);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             strand_r;

  // working registers
  logic [31:0]        pos_r;
  logic [31:0]        len_r, len_nxt;
  logic [31:0]        prev_r, prev_nxt;
  logic [COORD_W-1:0] base_r, base_nxt;
  logic [COORD_W-1:0] bound_a_r, bound_b_r;
  logic [COORD_W-1:0] f_r, f_nxt;
  logic [COORD_W-1:0] l_r, l_nxt;
  split_case_t        case_r, case_nxt;

  // output register
  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [COORD_W-1:0] out_start_r;
  logic [31:0]        out_end_r;
  logic [31:0]        out_mapped_r;
  status_t            out_status_r;
  logic               out_last_r;

  // result being loaded
  logic               out_load;
  kind_t              ld_kind;
  logic [COORD_W-1:0] ld_start;
  logic [31:0]        ld_end;
  logic [31:0]        ld_mapped;
  status_t            ld_status;
  logic               ld_last;

  // table ports
  logic             wr_en;
  exon_t            wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  exon_t            rd_data;

  logic out_free;
  logic in_accept;
  logic pos_gt_len;

  // split segment decode
  kind_t              kind_lo, kind_hi;
  logic [31:0]        a_m1, b_m1;
  logic [1:0]         last_phase;
  kind_t              seg_kind;
  logic [COORD_W-1:0] seg_start;
  logic [31:0]        seg_end;
  logic [CNT_W-1:0]   k_inc;
  logic [31:0]        span_len;

  etcm_table #(
    .DEPTH (MAX_EXONS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free   = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && out_free;
  assign in_accept  = in_if.valid && in_if.ready;
  assign wr_data    = '{first: in_if.exon_first, last: in_if.exon_last};
  assign pos_gt_len = $signed(pos_r) > $signed(len_r);
  assign k_inc      = k_r + ONE_CNT;
  assign span_len   = {1'b0, rd_data.last} - {1'b0, rd_data.first} + 32'd1;

  // segment bounds and kinds by strand
  assign kind_lo = strand_r ? KIND_UTR3 : KIND_UTR5;
  assign kind_hi = strand_r ? KIND_UTR5 : KIND_UTR3;
  assign a_m1    = {1'b0, bound_a_r} - 32'd1;
  assign b_m1    = {1'b0, bound_b_r} - 32'd1;

  // current segment of the exon under split
  always_comb begin
    last_phase = 2'd0;
    seg_kind   = KIND_CDS;
    seg_start  = f_r;
    seg_end    = {1'b0, l_r};
    case (case_r)
      SPL_BELOW: begin
        seg_kind = kind_lo;
      end
      SPL_ENTER: begin
        last_phase = 2'd1;
        if (phase_r == 2'd0) begin
          seg_kind = kind_lo;
          seg_end  = a_m1;
        end else begin
          seg_start = bound_a_r;
        end
      end
      SPL_SPAN: begin
        last_phase = 2'd2;
        if (phase_r == 2'd0) begin
          seg_kind = kind_lo;
          seg_end  = a_m1;
        end else if (phase_r == 2'd1) begin
          seg_start = bound_a_r;
          seg_end   = b_m1;
        end else begin
          seg_kind  = kind_hi;
          seg_start = bound_b_r;
        end
      end
      SPL_INSIDE: begin
        seg_kind = KIND_CDS;
      end
      SPL_ABOVE: begin
        seg_kind = kind_hi;
      end
      SPL_LEAVE: begin
        last_phase = 2'd1;
        if (phase_r == 2'd0) begin
          seg_end = b_m1;
        end else begin
          seg_kind  = kind_hi;
          seg_start = bound_b_r;
        end
      end
      default: begin
        seg_kind = KIND_NONE;
      end
    endcase
  end

  // sequencer: next state, table access and result load
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    phase_nxt = phase_r;
    len_nxt   = len_r;
    prev_nxt  = prev_r;
    base_nxt  = base_r;
    f_nxt     = f_r;
    l_nxt     = l_r;
    case_nxt  = case_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = k_r[IDX_W-1:0];
    out_load  = 1'b0;
    ld_kind   = KIND_NONE;
    ld_start  = '0;
    ld_end    = '0;
    ld_mapped = '0;
    ld_status = ST_OK;
    ld_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (mode_t'(in_if.mode))
            MODE_APPEND: begin
              out_load = 1'b1;
              if (count_r < MAX_CNT) begin
                wr_en     = 1'b1;
                count_nxt = count_r + ONE_CNT;
              end else begin
                ld_status = ST_FULL;
              end
            end
            MODE_CLEAR: begin
              out_load  = 1'b1;
              count_nxt = '0;
            end
            MODE_MAP: begin
              if (count_r == '0) begin
                out_load  = 1'b1;
                ld_status = ST_UNMAPPED;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                k_nxt     = '0;
                len_nxt   = '0;
                prev_nxt  = '0;
                state_nxt = S_MAP_WALK;
              end
            end
            MODE_SPLIT: begin
              if (count_r == '0) begin
                out_load = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                k_nxt     = '0;
                state_nxt = S_SPL_CLASS;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      // one exon per cycle: accumulate transcript length while below position
      S_MAP_WALK: begin
        if (pos_gt_len && (k_r < count_r)) begin
          prev_nxt = len_r;
          len_nxt  = len_r + span_len;
          base_nxt = rd_data.first;
          k_nxt    = k_inc;
          if (k_inc < count_r) begin
            rd_en   = 1'b1;
            rd_addr = k_inc[IDX_W-1:0];
          end
        end else begin
          if (k_r == '0) begin
            base_nxt = rd_data.first;
          end
          state_nxt = S_MAP_OUT;
        end
      end

      // offset into the found exon, or unmapped past the transcript end
      S_MAP_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (pos_gt_len) begin
            ld_status = ST_UNMAPPED;
          end else begin
            ld_mapped = pos_r - prev_r + {1'b0, base_r};
          end
        end
      end

      // place the exon against the coding bounds
      S_SPL_CLASS: begin
        f_nxt     = rd_data.first;
        l_nxt     = rd_data.last;
        phase_nxt = 2'd0;
        state_nxt = S_SPL_EMIT;
        if (rd_data.last < bound_a_r) begin
          case_nxt = SPL_BELOW;
        end else if ((rd_data.first < bound_a_r) && (rd_data.last < bound_b_r)) begin
          case_nxt = SPL_ENTER;
        end else if (rd_data.first < bound_a_r) begin
          case_nxt = SPL_SPAN;
        end else if (rd_data.last < bound_b_r) begin
          case_nxt = SPL_INSIDE;
        end else if (rd_data.first >= bound_b_r) begin
          case_nxt = SPL_ABOVE;
        end else begin
          case_nxt = SPL_LEAVE;
        end
      end

      // one segment per cycle while the output register is free, then on to the next exon
      S_SPL_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_kind  = seg_kind;
          ld_start = seg_start;
          ld_end   = seg_end;
          ld_last  = (phase_r == last_phase) && (k_inc == count_r);
          if (phase_r == last_phase) begin
            if (k_inc < count_r) begin
              rd_en     = 1'b1;
              rd_addr   = k_inc[IDX_W-1:0];
              k_nxt     = k_inc;
              state_nxt = S_SPL_CLASS;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            phase_nxt = phase_r + 2'd1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      phase_r     <= 2'd0;
      strand_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      k_r      <= k_nxt;
      phase_r  <= phase_nxt;
      if (cfg_we) begin
        strand_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    prev_r <= prev_nxt;
    base_r <= base_nxt;
    f_r    <= f_nxt;
    l_r    <= l_nxt;
    case_r <= case_nxt;
    if (in_accept) begin
      pos_r     <= in_if.rna_position;
      bound_a_r <= strand_r ? in_if.cds_stop : in_if.cds_start;
      bound_b_r <= strand_r ? in_if.cds_start : in_if.cds_stop;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r   <= ld_kind;
      out_start_r  <= ld_start;
      out_end_r    <= ld_end;
      out_mapped_r <= ld_mapped;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.kind       = out_kind_r;
  assign out_if.seg_start  = out_start_r;
  assign out_if.seg_end    = out_end_r;
  assign out_if.mapped_pos = out_mapped_r;
  assign out_if.status     = out_status_r;
  assign out_if.last       = out_last_r;

endmodule
